@@ src/gvs_pkg.sv @@
package gvs_pkg;

	localparam int unsigned W_FLD = 48;
	localparam int unsigned W_ACC = 64;
	localparam int unsigned W_SQ = 98;

	// saturation bound of intermediates, 2^62 - 1
	localparam logic [63:0] LIM = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// register indexes
	localparam logic REG_STEP_TIME = 1'b0;
	localparam logic REG_GRAV_PARAM = 1'b1;

	// program addresses
	localparam logic [5:0] PC_ACC0 = 6'd0;
	localparam logic [5:0] PC_SQ = 6'd17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MULW,
		ST_ROOTW,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_SQRT,
		OP_RECIP,
		OP_END
	} op_kind_t;

	typedef enum logic [3:0] {
		SRC_K,
		SRC_INV,
		SRC_M,
		SRC_G,
		SRC_U,
		SRC_POS,
		SRC_VEL,
		SRC_A0,
		SRC_T,
		SRC_D,
		SRC_ASUM
	} src_t;

	typedef enum logic [3:0] {
		DST_M,
		DST_G,
		DST_U,
		DST_A0,
		DST_A1,
		DST_VT,
		DST_T,
		DST_POSU,
		DST_VELU,
		DST_SQ0,
		DST_SQ
	} dst_t;

	typedef struct packed {
		op_kind_t   kind;
		src_t       sa;
		src_t       sb;
		logic [1:0] idx;
		logic [6:0] sh;
		dst_t       dst;
	} op_t;

	typedef struct packed {
		logic        start;
		logic        neg;
		logic [6:0]  sh;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                start_sqrt;
		logic                start_div;
		logic [W_SQ-1:0]     radicand;
		logic [W_FLD-1:0]    divisor;
	} root_req_t;

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > LIM65)
			return LIM;
		else if (s < -LIM65)
			return 64'(-LIM65);
		return s[63:0];
	endfunction

	function automatic logic [47:0] sat48(input logic [63:0] x);
		if ($signed(x) > MAX48)
			return MAX48[47:0];
		else if ($signed(x) < MIN48)
			return MIN48[47:0];
		return x[47:0];
	endfunction

	function automatic logic [63:0] sext48(input logic [47:0] x);
		return {{16{x[47]}}, x};
	endfunction

endpackage

@@ src/gvs_in_if.sv @@
interface gvs_in_if;
	import gvs_pkg::*;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [47:0] load_pos_x;
	logic [47:0] load_pos_y;
	logic [47:0] load_pos_z;
	logic [47:0] load_vel_x;
	logic [47:0] load_vel_y;
	logic [47:0] load_vel_z;

	modport source (output valid, req_type, load_pos_x, load_pos_y, load_pos_z,
		load_vel_x, load_vel_y, load_vel_z, input ready);
	modport sink (input valid, req_type, load_pos_x, load_pos_y, load_pos_z,
		load_vel_x, load_vel_y, load_vel_z, output ready);
endinterface

@@ src/gvs_out_if.sv @@
interface gvs_out_if;
	import gvs_pkg::*;
	logic        valid;
	logic        ready;
	logic [47:0] pos_x;
	logic [47:0] pos_y;
	logic [47:0] pos_z;
	logic [47:0] vel_x;
	logic [47:0] vel_y;
	logic [47:0] vel_z;
	logic [47:0] dist_now;
	logic [47:0] dist_before;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		dist_now, dist_before, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		dist_now, dist_before, output ready);
endinterface

@@ src/gvs_mul.sv @@
module gvs_mul
	import gvs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  mul_req_t     req,
	output logic         done,
	output logic [127:0] raw,
	output logic [63:0]  res
);

	logic         busy_q;
	logic [2:0]   cnt_q;
	logic         neg_q;
	logic [6:0]   sh_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [63:0]  res_q;
	logic         done_q;
	logic [31:0]  ai;
	logic [31:0]  bj;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] shifted;
	logic [61:0]  mag;

	// pick one 32x32 partial product per cycle
	always_comb begin
		ai = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		bj = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = 64'(ai) * 64'(bj);
		case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
			2'd0:    pp_sh = {64'd0, pp};
			2'd1:    pp_sh = {32'd0, pp, 32'd0};
			default: pp_sh = {pp, 64'd0};
		endcase
		shifted = acc_q >> sh_q;
		mag = (|shifted[127:62]) ? LIM[61:0] : shifted[61:0];
	end

	// accumulate four partial products, then shift and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			neg_q <= req.neg;
			sh_q  <= req.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4)
				res_q <= neg_q ? -{2'b00, mag} : {2'b00, mag};
			else
				acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign raw  = acc_q;
	assign res  = res_q;

endmodule

@@ src/gvs_root.sv @@
module gvs_root
	import gvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  root_req_t   req,
	output logic        done,
	output logic [47:0] root,
	output logic [63:0] inv
);

	logic            busy_q;
	logic            div_q;
	logic [6:0]      cnt_q;
	logic            done_q;
	logic [W_SQ-1:0] rad_q;
	logic [51:0]     rem_q;
	logic [48:0]     root_q;
	logic [63:0]     quo_q;
	logic [47:0]     dvs_q;
	logic [51:0]     rem_sq;
	logic [51:0]     trial;
	logic [51:0]     rem_dv;
	logic            sq_ge;
	logic            dv_ge;

	// one root bit or one quotient bit per cycle
	always_comb begin
		rem_sq = {rem_q[49:0], rad_q[W_SQ-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		sq_ge  = rem_sq >= trial;
		rem_dv = {rem_q[50:0], 1'b0};
		dv_ge  = rem_dv >= {4'd0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start_sqrt) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd48;
			end else if (req.start_div) begin
				// radius of zero or one saturates at once
				busy_q <= (req.divisor > 48'd1);
				done_q <= (req.divisor <= 48'd1);
				cnt_q  <= 7'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start_sqrt) begin
			div_q  <= 1'b0;
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (req.start_div) begin
			div_q <= 1'b1;
			dvs_q <= req.divisor;
			rem_q <= 52'd1;
			quo_q <= (req.divisor <= 48'd1) ? '1 : '0;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= dv_ge ? rem_dv - {4'd0, dvs_q} : rem_dv;
				quo_q <= {quo_q[62:0], dv_ge};
			end else begin
				rad_q  <= {rad_q[W_SQ-3:0], 2'b00};
				rem_q  <= sq_ge ? rem_sq - trial : rem_sq;
				root_q <= {root_q[47:0], sq_ge};
			end
		end
	end

	assign done = done_q;
	assign root = root_q[47:0];
	assign inv  = quo_q;

endmodule

@@ src/central_gravity_verlet_step_unit.sv @@
// channel    dir  handshake      payload
// item_in    in   valid/ready    req_type, load_pos_x/y/z, load_vel_x/y/z
// item_out   out  valid/ready    pos_x/y/z, vel_x/y/z, dist_now, dist_before
// apb        in   psel/penable   step_time at 0x0, grav_param at 0x8
//
// One item at a time; item_in is ready only while idle. Each multiply runs on one
// shared 32x32 unit (issue, four partial products, shift, done), the root and the
// reciprocal on one digit unit; a radius of zero or one LSB saturates the reciprocal.
// A step item runs 31 multiplies; a load item runs only the three squares, the root
// and the reciprocal. Reset clears control, particle and distance state but not the
// scratch or output data registers; step_time resets to one second.
// A result waiting on item_out stalls the next item in ST_OUT until it is taken.
module central_gravity_verlet_step_unit
	import gvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	gvs_in_if.sink      item_in,
	gvs_out_if.source   item_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	state_t      state_q, state_d;
	logic [5:0]  pc_q;
	logic        load_q;
	logic [31:0] step_time_q;
	logic [63:0] grav_q;
	logic [47:0] pos_q [3];
	logic [47:0] vel_q [3];
	logic [63:0] a0_q [3];
	logic [63:0] a1_q [3];
	logic [47:0] dist_q;
	logic [63:0] inv_q;
	logic [47:0] prev_q;
	logic [63:0] m_q, g_q, u_q, vt_q, t_q;
	logic [W_SQ-1:0] sq_q;
	logic        oval_q;
	logic [47:0] opos_q [3];
	logic [47:0] ovel_q [3];
	logic [47:0] odist_q, oprev_q;

	op_t         op;
	mul_req_t    mreq;
	root_req_t   rreq;
	logic        mdone, rdone;
	logic [127:0] mraw;
	logic [63:0] mres;
	logic [47:0] rroot;
	logic [63:0] rinv;
	logic        accept, cfg_wr, out_free;
	logic        nega, negb;
	logic [63:0] maga, magb;

	assign accept   = item_in.valid && item_in.ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !oval_q || item_out.ready;
	assign item_in.ready = (state_q == ST_IDLE);

	// decode the program step
	always_comb begin
		op = '{OP_END, SRC_K, SRC_K, 2'd0, 7'd0, DST_M};
		case (pc_q)
			6'd0, 6'd22:  op = '{OP_MUL, SRC_K,   SRC_INV, 2'd0, 7'd32, DST_M};
			6'd1, 6'd23:  op = '{OP_MUL, SRC_M,   SRC_INV, 2'd0, 7'd32, DST_G};
			6'd2, 6'd24:  op = '{OP_MUL, SRC_POS, SRC_INV, 2'd0, 7'd2,  DST_U};
			6'd3, 6'd25:  op = '{OP_MUL, SRC_G,   SRC_U,   2'd0, 7'd62, DST_A0};
			6'd4, 6'd26:  op = '{OP_MUL, SRC_POS, SRC_INV, 2'd1, 7'd2,  DST_U};
			6'd5, 6'd27:  op = '{OP_MUL, SRC_G,   SRC_U,   2'd1, 7'd62, DST_A0};
			6'd6, 6'd28:  op = '{OP_MUL, SRC_POS, SRC_INV, 2'd2, 7'd2,  DST_U};
			6'd7, 6'd29:  op = '{OP_MUL, SRC_G,   SRC_U,   2'd2, 7'd62, DST_A0};
			6'd8:  op = '{OP_MUL, SRC_VEL, SRC_D, 2'd0, 7'd28, DST_VT};
			6'd9:  op = '{OP_MUL, SRC_A0,  SRC_D, 2'd0, 7'd16, DST_T};
			6'd10: op = '{OP_MUL, SRC_T,   SRC_D, 2'd0, 7'd41, DST_POSU};
			6'd11: op = '{OP_MUL, SRC_VEL, SRC_D, 2'd1, 7'd28, DST_VT};
			6'd12: op = '{OP_MUL, SRC_A0,  SRC_D, 2'd1, 7'd16, DST_T};
			6'd13: op = '{OP_MUL, SRC_T,   SRC_D, 2'd1, 7'd41, DST_POSU};
			6'd14: op = '{OP_MUL, SRC_VEL, SRC_D, 2'd2, 7'd28, DST_VT};
			6'd15: op = '{OP_MUL, SRC_A0,  SRC_D, 2'd2, 7'd16, DST_T};
			6'd16: op = '{OP_MUL, SRC_T,   SRC_D, 2'd2, 7'd41, DST_POSU};
			6'd17: op = '{OP_MUL, SRC_POS, SRC_POS, 2'd0, 7'd0, DST_SQ0};
			6'd18: op = '{OP_MUL, SRC_POS, SRC_POS, 2'd1, 7'd0, DST_SQ};
			6'd19: op = '{OP_MUL, SRC_POS, SRC_POS, 2'd2, 7'd0, DST_SQ};
			6'd20: op = '{OP_SQRT,  SRC_K, SRC_K, 2'd0, 7'd0, DST_M};
			6'd21: op = '{OP_RECIP, SRC_K, SRC_K, 2'd0, 7'd0, DST_M};
			6'd30: op = '{OP_MUL, SRC_ASUM, SRC_D, 2'd0, 7'd29, DST_VELU};
			6'd31: op = '{OP_MUL, SRC_ASUM, SRC_D, 2'd1, 7'd29, DST_VELU};
			6'd32: op = '{OP_MUL, SRC_ASUM, SRC_D, 2'd2, 7'd29, DST_VELU};
			default: op = '{OP_END, SRC_K, SRC_K, 2'd0, 7'd0, DST_M};
		endcase
		// second acceleration pass writes the new set
		if (pc_q >= 6'd22 && op.dst == DST_A0)
			op.dst = DST_A1;
	end

	function automatic logic [64:0] operand(input src_t s, input logic [1:0] i);
		logic [63:0] v;
		v = '0;
		case (s)
			SRC_INV: return {1'b0, inv_q};
			SRC_D:   return {1'b0, 32'd0, step_time_q};
			SRC_K:   v = grav_q;
			SRC_M:   v = m_q;
			SRC_G:   v = g_q;
			SRC_U:   v = u_q;
			SRC_T:   v = t_q;
			SRC_POS: v = sext48(pos_q[i]);
			SRC_VEL: v = sext48(vel_q[i]);
			SRC_A0:  v = a0_q[i];
			SRC_ASUM: v = add_sat(a0_q[i], a1_q[i]);
			default: v = '0;
		endcase
		return {v[63], v[63] ? -v : v};
	endfunction

	// feed the shared units
	always_comb begin
		{nega, maga} = operand(op.sa, op.idx);
		{negb, magb} = operand(op.sb, op.idx);
		mreq.start = (state_q == ST_ISSUE) && (op.kind == OP_MUL);
		mreq.neg   = nega ^ negb;
		mreq.sh    = op.sh;
		mreq.a     = maga;
		mreq.b     = magb;
		rreq.start_sqrt = (state_q == ST_ISSUE) && (op.kind == OP_SQRT);
		rreq.start_div  = (state_q == ST_ISSUE) && (op.kind == OP_RECIP);
		rreq.radicand   = sq_q;
		rreq.divisor    = dist_q;
	end

	gvs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mdone),
		.raw    (mraw),
		.res    (mres)
	);

	gvs_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.done   (rdone),
		.root   (rroot),
		.inv    (rinv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequence the program
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (accept)
					state_d = ST_ISSUE;
			ST_ISSUE:
				case (op.kind)
					OP_MUL:   state_d = ST_MULW;
					OP_SQRT, OP_RECIP: state_d = ST_ROOTW;
					default:  state_d = ST_OUT;
				endcase
			ST_MULW:
				if (mdone)
					state_d = ST_ISSUE;
			ST_ROOTW:
				if (rdone)
					state_d = (op.kind == OP_RECIP && load_q) ? ST_OUT : ST_ISSUE;
			ST_OUT:
				if (out_free)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// particle state and scratch registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			load_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
			dist_q <= '0;
			inv_q  <= '0;
			prev_q <= '0;
		end else begin
			if (accept) begin
				load_q <= (item_in.req_type == REQ_LOAD);
				if (item_in.req_type == REQ_LOAD) begin
					pc_q     <= PC_SQ;
					pos_q[0] <= item_in.load_pos_x;
					pos_q[1] <= item_in.load_pos_y;
					pos_q[2] <= item_in.load_pos_z;
					vel_q[0] <= item_in.load_vel_x;
					vel_q[1] <= item_in.load_vel_y;
					vel_q[2] <= item_in.load_vel_z;
				end else begin
					pc_q   <= PC_ACC0;
					prev_q <= dist_q;
				end
			end
			if (state_q == ST_MULW && mdone) begin
				pc_q <= pc_q + 6'd1;
				if (op.dst == DST_POSU)
					pos_q[op.idx] <= sat48(add_sat(add_sat(sext48(pos_q[op.idx]), vt_q),
						mres));
				if (op.dst == DST_VELU)
					vel_q[op.idx] <= sat48(add_sat(sext48(vel_q[op.idx]), mres));
			end
			if (state_q == ST_ROOTW && rdone) begin
				pc_q <= pc_q + 6'd1;
				if (op.kind == OP_SQRT)
					dist_q <= rroot;
				else begin
					inv_q <= rinv;
					if (load_q)
						prev_q <= dist_q;
				end
			end
		end
	end

	// capture multiply results
	always_ff @(posedge clk) begin
		if (state_q == ST_MULW && mdone) begin
			case (op.dst)
				DST_M:   m_q  <= mres;
				DST_G:   g_q  <= mres;
				DST_U:   u_q  <= mres;
				DST_A0:  a0_q[op.idx] <= mres;
				DST_A1:  a1_q[op.idx] <= mres;
				DST_VT:  vt_q <= mres;
				DST_T:   t_q  <= mres;
				DST_SQ0: sq_q <= mraw[W_SQ-1:0];
				DST_SQ:  sq_q <= sq_q + mraw[W_SQ-1:0];
				default: ;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 32'h0001_0000;
			grav_q      <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_STEP_TIME)
				step_time_q <= pwdata[31:0];
			else
				grav_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_GRAV_PARAM) ? grav_q : {32'd0, step_time_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			oval_q <= 1'b0;
		else if (state_q == ST_OUT && out_free)
			oval_q <= 1'b1;
		else if (item_out.ready)
			oval_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			for (int i = 0; i < 3; i++) begin
				opos_q[i] <= pos_q[i];
				ovel_q[i] <= vel_q[i];
			end
			odist_q <= dist_q;
			oprev_q <= prev_q;
		end
	end

	assign item_out.valid       = oval_q;
	assign item_out.pos_x       = opos_q[0];
	assign item_out.pos_y       = opos_q[1];
	assign item_out.pos_z       = opos_q[2];
	assign item_out.vel_x       = ovel_q[0];
	assign item_out.vel_y       = ovel_q[1];
	assign item_out.vel_z       = ovel_q[2];
	assign item_out.dist_now    = odist_q;
	assign item_out.dist_before = oprev_q;

endmodule
